// ===== rtl/core/vafc_pkg.sv =====
// vafc_pkg: shared types and constants for the vertex attribute format converter
// no dependencies
`timescale 1ns / 1ps
package vafc_pkg;
	typedef enum logic {
		KIND_FIXED = 1'b0,
		KIND_BYTE  = 1'b1
	} kind_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] raw_value;
		logic               last_element;
	} in_word_t;

	typedef struct packed {
		logic [31:0] result_word;
		logic        last_out;
	} out_word_t;

	// biased exponent of 2^-16
	localparam logic [7:0] EXP_BASE = 8'd111;
endpackage

// ===== rtl/core/vafc_if.sv =====
// vafc_if: valid/ready channel interfaces for input and result words
// depends on vafc_pkg
`timescale 1ns / 1ps
interface vafc_in_if;
	import vafc_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vafc_out_if;
	import vafc_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/vertex_attribute_format_converter.sv =====
// vertex_attribute_format_converter: top level, input register, converter, result register
// depends on vafc_pkg, vafc_if, vafc_convert
`timescale 1ns / 1ps
// Usage:
//   in_ch  carries kind, raw_value and last_element; a word moves when
//          valid and ready are both high.
//   out_ch carries result_word and last_out under the same handshake.
//   Kind fixed turns a signed 16.16 word into float32 bits (nearest even);
//   kind byte sign-extends the low byte into the 32-bit result.
// Path: an accepted word is held in the input register, then loaded
//   into the result register, which drives out_ch.valid.
// Throughput: one word per cycle while out_ch.ready stays high; the conversion is a single registered pass.
// Reset: arst_n clears both valid flags; no word is held afterward.
// Stall: when out_ch.ready is low the result register holds its word and
//   the input register still fills; in_ch.ready drops only when both
//   stages hold words and the output is stalled.
module vertex_attribute_format_converter (
	input  logic       clk,
	input  logic       arst_n,
	vafc_in_if.sink    in_ch,
	vafc_out_if.source out_ch
);
	import vafc_pkg::*;

	in_word_t  in_s1;
	logic      vld_s1;
	out_word_t res_s2;
	logic      vld_s2;
	out_word_t conv;
	logic      adv_s2;

	assign adv_s2      = vld_s1 && (!vld_s2 || out_ch.ready);
	assign in_ch.ready = !vld_s1 || adv_s2;

	// conversion logic
	vafc_convert u_conv (
		.in_word  (in_s1),
		.out_word (conv)
	);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) vld_s1 <= in_ch.valid;
			if (!vld_s2 || out_ch.ready) vld_s2 <= vld_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) in_s1 <= in_ch.data;
		if (adv_s2) res_s2 <= conv;
	end

	assign out_ch.valid = vld_s2;
	assign out_ch.data  = res_s2;
endmodule

// ===== rtl/core/vafc_convert.sv =====
// vafc_convert: combinational fixed-to-float and byte-to-32-bit sign-extension conversion
// depends on vafc_pkg
`timescale 1ns / 1ps
module vafc_convert (
	input  vafc_pkg::in_word_t  in_word,
	output vafc_pkg::out_word_t out_word
);
	import vafc_pkg::*;

	logic        sign;
	logic [31:0] mag;
	logic [4:0]  top;
	logic [31:0] norm;
	logic [24:0] mant_r;
	logic        guard;
	logic        sticky;
	logic [7:0]  expo;
	logic [31:0] fbits;
	logic [31:0] bbits;

	// leading one position
	always_comb begin
		top = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag[i]) top = 5'(i);
		end
	end

	assign sign = in_word.raw_value[31];
	assign mag  = sign ? (32'd0 - in_word.raw_value) : in_word.raw_value;
	// left-justify so the leading one sits at bit 31
	assign norm = mag << (5'd31 - top);

	// round to nearest even on the bits below the 24-bit mantissa
	always_comb begin
		guard  = norm[7];
		sticky = |norm[6:0];
		mant_r = {1'b0, norm[31:8]} + 25'(guard & (sticky | norm[8]));
		expo   = EXP_BASE + {3'd0, top} + {7'd0, mant_r[24]};
		if (mag == 32'd0) begin
			fbits = 32'd0;
		end else begin
			fbits = {sign, expo, mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
		end
	end

	assign bbits = {{24{in_word.raw_value[7]}}, in_word.raw_value[7:0]};

	assign out_word.result_word = (in_word.kind == KIND_BYTE) ? bbits : fbits;
	assign out_word.last_out    = in_word.last_element;
endmodule

// ===== sim/vertex_attribute_format_converter_tb.sv =====
// vertex_attribute_format_converter_tb: checks fixed-to-float and byte-to-32-bit sign-extension conversion
// drives random and directed words with random idling; depends on vafc_pkg, vafc_if and the rtl
`timescale 1ns / 1ps
module vertex_attribute_format_converter_tb;
	import vafc_pkg::*;

	// predicted results, oldest first, with mismatch bookkeeping
	class conv_scoreboard;
		out_word_t pending[$];
		int        mismatches;
		int        extras;

		function automatic logic [31:0] fixed_to_float(logic [31:0] w);
			logic        sgn;
			logic [31:0] mag;
			logic [31:0] mant;
			logic [31:0] rem;
			logic [31:0] half;
			logic [7:0]  ex;
			int          msb;
			int          sh;
			sgn = w[31];
			mag = sgn ? (32'd0 - w) : w;
			if (mag == 32'd0)
				return 32'd0;
			msb = 0;
			for (int i = 0; i < 32; i++)
				if (mag[i])
					msb = i;
			ex = EXP_BASE + 8'(msb);
			if (msb <= 23) begin
				mant = mag << (23 - msb);
			end else begin
				sh = msb - 23;
				rem = mag & ((32'd1 << sh) - 32'd1);
				half = 32'd1 << (sh - 1);
				mant = mag >> sh;
				if (rem > half || (rem == half && mant[0]))
					mant++;
				if (mant == (32'd1 << 24)) begin
					mant = mant >> 1;
					ex++;
				end
			end
			return {sgn, ex, mant[22:0]};
		endfunction

		function void note_input(in_word_t w);
			out_word_t r;
			if (kind_t'(w.kind) == KIND_FIXED)
				r.result_word = fixed_to_float(w.raw_value);
			else
				r.result_word = {{24{w.raw_value[7]}}, w.raw_value[7:0]};
			r.last_out = w.last_element;
			pending.push_back(r);
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp_w;
			if (pending.size() == 0) begin
				extras++;
				if (mismatches + extras <= 10)
					$display("unexpected result word %h last %b", got.result_word, got.last_out);
				return;
			end
			exp_w = pending.pop_front();
			if (got.result_word !== exp_w.result_word || got.last_out !== exp_w.last_out) begin
				mismatches++;
				if (mismatches + extras <= 10)
					$display("mismatch: expected %h/%b actual %h/%b", exp_w.result_word,
						exp_w.last_out, got.result_word, got.last_out);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	vafc_in_if  in_ch();
	vafc_out_if out_ch();
	conv_scoreboard board = new();

	int  send_idle_pct = 25;
	int  recv_idle_pct = 53;
	bit  hold_off = 1'b0;
	int  quiet_cycles = 0;

	vertex_attribute_format_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #4 clk = ~clk;

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				board.note_input(in_ch.data);
			if (out_ch.valid && out_ch.ready)
				board.check_result(out_ch.data);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (quiet_cycles > 2000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver ready, changed at the falling edge
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// long receiver stall while the sender keeps offering
	initial begin
		wait (arst_n);
		repeat (300) @(posedge clk);
		hold_off = 1'b1;
		repeat (60) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic send_word(logic k, logic [31:0] raw, logic lst);
		in_word_t w;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		w.kind = k;
		w.raw_value = raw;
		w.last_element = lst;
		in_ch.data <= w;
		in_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_random(int count);
		logic [31:0] raw;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: raw = $urandom;
				1: raw = $urandom >> $urandom_range(31);
				2: raw = 32'd0 - ($urandom >> $urandom_range(31));
				default: raw = $urandom_range(1) ? (32'h0100_0000 << $urandom_range(7)) +
					$urandom_range(3) * (32'd1 << $urandom_range(7)) : $urandom;
			endcase
			send_word($urandom_range(1) ? KIND_BYTE : KIND_FIXED, raw, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		static logic [31:0] directed [] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0100_0001,
			32'h0100_0003, 32'h0300_0002, 32'h0000_007F, 32'h0000_0080, 32'hFFFF_FF80,
			32'h1234_56FF};
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// extremes, rounding ties and zero in both kinds
		foreach (directed[i]) begin
			send_word(KIND_FIXED, directed[i], i[0]);
			send_word(KIND_BYTE, directed[i], ~i[0]);
		end
		send_random(500);
		send_idle_pct = 53;
		recv_idle_pct = 25;
		send_random(500);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(520);
		in_ch.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.extras == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== vertex_attribute_format_converter.f =====
rtl/core/vafc_pkg.sv
rtl/core/vafc_if.sv
rtl/core/vafc_convert.sv
rtl/core/vertex_attribute_format_converter.sv
sim/vertex_attribute_format_converter_tb.sv
